/* src/temd_pkg.sv */
package temd_pkg;

   localparam int GatherCapacityDefault = 64;
   localparam int GatherKeep = 6;
   localparam int CountWidth = 48;
   localparam int CodeWidth = 4;

   localparam logic [7:0] ByteEsc = 8'h1b;
   localparam logic [7:0] ByteStop = 8'h1d;
   localparam logic [7:0] ByteBracket = 8'h5b;
   localparam logic [7:0] ByteTilde = 8'h7e;
   localparam logic [7:0] ByteLess = 8'h3c;
   localparam logic [7:0] ByteUpperI = 8'h49;
   localparam logic [7:0] ByteUpperO = 8'h4f;
   localparam logic [7:0] ByteUpperM = 8'h4d;
   localparam logic [7:0] ByteLowerM = 8'h6d;
   localparam logic [7:0] ByteLowerU = 8'h75;
   localparam logic [7:0] ByteTwo = 8'h32;
   localparam logic [7:0] ByteZero = 8'h30;
   localparam logic [7:0] ByteOne = 8'h31;

   typedef enum logic [CodeWidth-1:0] {
      CODE_NONE          = 4'd0,
      CODE_FOCUS_IN      = 4'd1,
      CODE_FOCUS_OUT     = 4'd2,
      CODE_PASTE_BEGIN   = 4'd3,
      CODE_PASTE_END     = 4'd4,
      CODE_MOUSE_PRESS   = 4'd5,
      CODE_MOUSE_RELEASE = 4'd6,
      CODE_KEY_REPORT    = 4'd7,
      CODE_STOP          = 4'd8
   } marker_code_type;

   typedef struct packed {
      logic [CountWidth-1:0] byte_number;
      marker_code_type       marker_code;
   } rsp_item_type;

endpackage

/* src/terminal_escape_marker_detector_unit.sv */
// a result is computed combinationally and registered into the output buffer when its item is accepted
// throughput: one item per cycle while the output buffer is not full, the detector updates on each accepted item
// a two-entry output buffer keeps input ready while one result waits
// reset (synchronous, active high) clears the candidate, paste flag, byte count
// and output buffer
module terminal_escape_marker_detector_unit
   import temd_pkg::*;
#(
   parameter int GATHER_CAPACITY = GatherCapacityDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // marker_code[3:0], byte_number[51:4], zero[55:52]
);

   logic         item_accept;
   rsp_item_type core_result, rsp_item;

   assign item_accept = req_tvalid && req_tready;

   temd_core #(
      .GATHER_CAPACITY(GATHER_CAPACITY)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .item_accept (item_accept),
      .in_byte     (req_tdata),
      .result      (core_result)
   );

   temd_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push       (item_accept),
      .push_item  (core_result),
      .push_ready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = {4'b0000, rsp_item.byte_number, rsp_item.marker_code};

endmodule

/* src/temd_core.sv */
module temd_core
   import temd_pkg::*;
#(
   parameter int GATHER_CAPACITY = GatherCapacityDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         item_accept,
   input  logic [7:0]   in_byte,
   output rsp_item_type result
);

   localparam int LenWidth = $clog2(GATHER_CAPACITY);
   localparam logic [LenWidth-1:0] LenLimit = LenWidth'(GATHER_CAPACITY - 1);
   localparam logic [LenWidth-1:0] LenThree = LenWidth'(3);
   localparam logic [LenWidth-1:0] LenFour = LenWidth'(4);
   localparam logic [LenWidth-1:0] LenKeep = LenWidth'(GatherKeep);
   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

   logic [LenWidth-1:0]   len_ff, len_in, len_base, len_gather;
   logic [7:0]            bytes_ff [GatherKeep];
   logic [7:0]            bytes_in [GatherKeep];
   logic                  paste_ff, paste_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  gather, csi;
   marker_code_type       code;

   always_comb begin
      len_base = (in_byte == ByteEsc) ? '0 : len_ff;
      gather = (len_base < LenLimit) && ((len_base != '0) || (in_byte == ByteEsc));
      len_gather = gather ? len_base + LenWidth'(1) : '0;
      for (int i = 0; i < GatherKeep; i++) begin
         bytes_in[i] = (gather && (len_base == LenWidth'(i))) ? in_byte : bytes_ff[i];
      end
      count_in = (count_ff < CountMax) ? count_ff + CountWidth'(1) : count_ff;

      code = CODE_NONE;
      len_in = len_gather;
      paste_in = paste_ff;
      csi = (len_gather >= LenThree) && (bytes_in[0] == ByteEsc) &&
            (bytes_in[1] == ByteBracket);
      if (paste_ff) begin
         if ((len_gather == LenKeep) && (bytes_in[0] == ByteEsc) &&
             (bytes_in[1] == ByteBracket) && (bytes_in[2] == ByteTwo) &&
             (bytes_in[3] == ByteZero) && (bytes_in[4] == ByteOne) &&
             (bytes_in[5] == ByteTilde)) begin
            code = CODE_PASTE_END;
            paste_in = 1'b0;
            len_in = '0;
         end
      end else if ((len_gather == LenThree) && csi && (bytes_in[2] == ByteUpperI)) begin
         code = CODE_FOCUS_IN;
         len_in = '0;
      end else if ((len_gather == LenThree) && csi && (bytes_in[2] == ByteUpperO)) begin
         code = CODE_FOCUS_OUT;
         len_in = '0;
      end else if ((len_gather == LenKeep) && csi && (bytes_in[2] == ByteTwo) &&
                   (bytes_in[3] == ByteZero) && (bytes_in[4] == ByteZero) &&
                   (bytes_in[5] == ByteTilde)) begin
         code = CODE_PASTE_BEGIN;
         paste_in = 1'b1;
         len_in = '0;
      end else if (csi && (len_gather >= LenFour) && (bytes_in[2] == ByteLess) &&
                   ((in_byte == ByteUpperM) || (in_byte == ByteLowerM))) begin
         code = (in_byte == ByteUpperM) ? CODE_MOUSE_PRESS : CODE_MOUSE_RELEASE;
         len_in = '0;
      end else if (csi && (in_byte == ByteLowerU)) begin
         code = CODE_KEY_REPORT;
         len_in = '0;
      end
      if (in_byte == ByteStop) begin
         code = CODE_STOP;
      end

      result.marker_code = code;
      result.byte_number = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         paste_ff <= 1'b0;
         count_ff <= '0;
      end else if (item_accept) begin
         len_ff <= len_in;
         paste_ff <= paste_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_accept) begin
         for (int i = 0; i < GatherKeep; i++) begin
            bytes_ff[i] <= bytes_in[i];
         end
      end
   end

endmodule

/* src/temd_skid.sv */
module temd_skid
   import temd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   output logic         push_ready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output rsp_item_type rsp_item
);

   logic         main_valid_ff, skid_valid_ff;
   rsp_item_type main_ff, skid_ff;
   logic         pop;

   assign pop = main_valid_ff && rsp_tready;
   assign push_ready = !skid_valid_ff;
   assign rsp_tvalid = main_valid_ff;
   assign rsp_item = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (skid_valid_ff) begin
            main_ff <= skid_ff;
         end else begin
            main_ff <= push_item;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_ff <= push_item;
         end else begin
            skid_ff <= push_item;
         end
      end
   end

endmodule

/* bench/tb_terminal_escape_marker_detector_unit.sv */
module tb_terminal_escape_marker_detector_unit;
   import temd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TargetItems = 1400;
   localparam int CycleLimit = 200000;
   localparam int DrainCycles = 8;
   localparam int HoldOffAt = 300;
   localparam int HoldOffCycles = 200;
   localparam logic [7:0] ByteSemi = 8'h3b;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;

   terminal_escape_marker_detector_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   logic [7:0]   byte_backlog [$];
   rsp_item_type expected_markers [$];

   int               cand_len = 0;
   logic [7:0]       cand_bytes [GatherKeep];
   logic             in_paste = 1'b0;
   logic [CountWidth-1:0] bytes_seen = '0;

   int cycle_count = 0;
   int checked = 0;
   int mismatches = 0;
   int accepted = 0;
   int input_stalls = 0;
   int marker_seen [9];
   int send_idle = 0;
   int recv_idle = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;

   // paste start or end candidate, last digit selects which
   function automatic logic paste_match(input logic [7:0] last);
      return cand_len == GatherKeep && cand_bytes[0] == ByteEsc &&
             cand_bytes[1] == ByteBracket && cand_bytes[2] == ByteTwo &&
             cand_bytes[3] == ByteZero && cand_bytes[4] == last &&
             cand_bytes[5] == ByteTilde;
   endfunction

   function automatic marker_code_type scan_byte(input logic [7:0] b);
      marker_code_type code;
      logic csi;
      code = CODE_NONE;
      if (b == ByteEsc) cand_len = 0;
      if (cand_len < GatherCapacityDefault - 1 && (cand_len > 0 || b == ByteEsc)) begin
         if (cand_len < GatherKeep) cand_bytes[cand_len] = b;
         cand_len++;
      end else begin
         cand_len = 0;
      end
      csi = cand_len >= 3 && cand_bytes[0] == ByteEsc && cand_bytes[1] == ByteBracket;
      if (in_paste) begin
         if (paste_match(ByteOne)) begin
            in_paste = 1'b0;
            cand_len = 0;
            code = CODE_PASTE_END;
         end
      end else if (csi && cand_len == 3 && cand_bytes[2] == ByteUpperI) begin
         cand_len = 0;
         code = CODE_FOCUS_IN;
      end else if (csi && cand_len == 3 && cand_bytes[2] == ByteUpperO) begin
         cand_len = 0;
         code = CODE_FOCUS_OUT;
      end else if (paste_match(ByteZero)) begin
         in_paste = 1'b1;
         cand_len = 0;
         code = CODE_PASTE_BEGIN;
      end else if (csi && cand_len >= 4 && cand_bytes[2] == ByteLess &&
                   (b == ByteUpperM || b == ByteLowerM)) begin
         cand_len = 0;
         code = (b == ByteUpperM) ? CODE_MOUSE_PRESS : CODE_MOUSE_RELEASE;
      end else if (csi && b == ByteLowerU) begin
         cand_len = 0;
         code = CODE_KEY_REPORT;
      end
      return code;
   endfunction

   function automatic rsp_item_type predict_marker(input logic [7:0] b);
      rsp_item_type r;
      if (bytes_seen != '1) bytes_seen = bytes_seen + 1'b1;
      r.marker_code = scan_byte(b);
      if (b == ByteStop) r.marker_code = CODE_STOP;
      r.byte_number = bytes_seen;
      return r;
   endfunction

   // mostly short gaps, a few long ones, and calm stretches with none
   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if ((cycle_count / 700) % 3 == 1) return 0;
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic push_byte(input logic [7:0] b);
      byte_backlog.push_back(b);
   endtask

   task automatic push_csi();
      push_byte(ByteEsc);
      push_byte(ByteBracket);
   endtask

   task automatic push_number();
      int n;
      n = $urandom_range(1, 3);
      repeat (n) push_byte(ByteZero + 8'($urandom_range(0, 9)));
   endtask

   task automatic push_paste(input logic [7:0] last);
      push_csi();
      push_byte(ByteTwo);
      push_byte(ByteZero);
      push_byte(last);
      push_byte(ByteTilde);
   endtask

   task automatic push_mouse(input logic [7:0] final_byte);
      push_csi();
      push_byte(ByteLess);
      push_number();
      push_byte(ByteSemi);
      push_number();
      push_byte(ByteSemi);
      push_number();
      push_byte(final_byte);
   endtask

   task automatic push_key();
      push_csi();
      push_number();
      if ($urandom_range(0, 1)) begin
         push_byte(ByteSemi);
         push_number();
      end
      push_byte(ByteLowerU);
   endtask

   task automatic push_paste_body();
      int n;
      int r;
      n = $urandom_range(0, 12);
      repeat (n) begin
         r = $urandom_range(0, 19);
         if (r == 0) begin
            push_csi();
            push_byte(ByteUpperI);
         end else if (r == 1) begin
            push_byte(ByteStop);
         end else if (r == 2) begin
            push_mouse(ByteUpperM);
         end else begin
            push_byte(8'($urandom_range(8'h20, 8'h7e)));
         end
      end
   endtask

   task automatic push_broken();
      int cut;
      int start;
      start = byte_backlog.size();
      case ($urandom_range(0, 3))
         0: push_paste(ByteZero);
         1: push_mouse(ByteLowerM);
         2: push_key();
         default: begin
            push_csi();
            push_byte(ByteUpperO);
         end
      endcase
      cut = $urandom_range(1, byte_backlog.size() - start - 1);
      while (byte_backlog.size() > start + cut) void'(byte_backlog.pop_back());
      push_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic fill_directed();
      push_byte(8'h00);
      push_byte(8'hff);
      push_csi();
      push_byte(ByteUpperI);
      push_csi();
      push_byte(ByteUpperO);
      push_paste(ByteZero);
      push_csi();
      push_byte(ByteUpperI);
      push_byte(ByteStop);
      push_paste(ByteOne);
      push_csi();
      push_byte(ByteLess);
      push_byte(ByteLowerM);
      push_csi();
      push_byte(ByteLowerU);
   endtask

   task automatic fill_random();
      int kind;
      int n;
      while (byte_backlog.size() < TargetItems) begin
         kind = $urandom_range(0, 99);
         if (kind < 15) begin
            n = $urandom_range(1, 4);
            repeat (n) push_byte(8'($urandom_range(0, 255)));
         end else if (kind < 25) begin
            push_csi();
            push_byte($urandom_range(0, 1) ? ByteUpperI : ByteUpperO);
         end else if (kind < 35) begin
            push_paste(ByteZero);
            push_paste_body();
            push_paste(ByteOne);
         end else if (kind < 53) begin
            push_mouse($urandom_range(0, 1) ? ByteUpperM : ByteLowerM);
         end else if (kind < 68) begin
            push_key();
         end else if (kind < 73) begin
            push_byte(ByteStop);
         end else if (kind < 89) begin
            push_broken();
         end else if (kind < 93) begin
            // candidate may reach capacity before the final byte, depending on the digit count
            push_csi();
            n = $urandom_range(58, 66);
            repeat (n) push_byte(ByteZero + 8'($urandom_range(0, 9)));
            push_byte(ByteLowerU);
         end else begin
            push_paste(ByteZero);
            push_paste_body();
            push_paste(8'($urandom_range(ByteTwo, 8'h39)));
            push_paste_body();
            push_paste(ByteOne);
         end
      end
   endtask

   // input driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_idle <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_markers.push_back(predict_marker(req_tdata));
            accepted <= accepted + 1;
         end
         if (req_tvalid && !req_tready) input_stalls <= input_stalls + 1;
         if (!req_tvalid || req_tready) begin
            if (send_idle > 0) begin
               send_idle <= send_idle - 1;
               req_tvalid <= 1'b0;
            end else if (byte_backlog.size() > 0) begin
               req_tdata <= byte_backlog.pop_front();
               req_tvalid <= 1'b1;
               send_idle <= pick_idle();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off so the output buffer fills and input stalls
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && checked >= HoldOffAt) begin
         hold_left <= HoldOffCycles;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result monitor and ready driver
   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_idle <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[51:0];
            if (expected_markers.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("unexpected item: code %0d byte %0d", got.marker_code,
                           got.byte_number);
            end else begin
               want = expected_markers.pop_front();
               if (got.marker_code !== want.marker_code ||
                   got.byte_number !== want.byte_number || rsp_tdata[55:52] !== 4'h0) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("mismatch at byte %0d: expected code %0d byte %0d, got %h",
                              want.byte_number, want.marker_code, want.byte_number,
                              rsp_tdata);
               end
               if (want.marker_code <= CODE_STOP)
                  marker_seen[want.marker_code] <= marker_seen[want.marker_code] + 1;
            end
            checked <= checked + 1;
         end
         if (recv_idle > 0) begin
            recv_idle <= recv_idle - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (hold_left == 0);
            recv_idle <= pick_idle();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      foreach (marker_seen[i]) marker_seen[i] = 0;
      fill_directed();
      fill_random();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (byte_backlog.size() != 0 || req_tvalid || expected_markers.size() != 0)
         @(negedge clock);
      repeat (DrainCycles) @(posedge clock);
      $display("%0d bytes sent, %0d results checked, input stalled %0d cycles",
               accepted, checked, input_stalls);
      $display("focus %0d/%0d paste %0d/%0d mouse %0d/%0d key %0d stop %0d plain %0d",
               marker_seen[CODE_FOCUS_IN], marker_seen[CODE_FOCUS_OUT],
               marker_seen[CODE_PASTE_BEGIN], marker_seen[CODE_PASTE_END],
               marker_seen[CODE_MOUSE_PRESS], marker_seen[CODE_MOUSE_RELEASE],
               marker_seen[CODE_KEY_REPORT], marker_seen[CODE_STOP],
               marker_seen[CODE_NONE]);
      if (mismatches == 0 && expected_markers.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
